// File: rtl/jts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner package
// Scan modes, token kinds, character codes and the result word layout.
// ----------------------------------------------------------------------------
package jts_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE     = 4'd0,
		MODE_STR      = 4'd1,
		MODE_ESC      = 4'd2,
		MODE_SIGN     = 4'd3,
		MODE_ZERO     = 4'd4,
		MODE_INT      = 4'd5,
		MODE_DOT      = 4'd6,
		MODE_FRAC     = 4'd7,
		MODE_EXP      = 4'd8,
		MODE_EXP_SIGN = 4'd9,
		MODE_EXP_DIG  = 4'd10,
		MODE_WORD     = 4'd11
	} mode_t;

	typedef enum logic [3:0] {
		KIND_END       = 4'd0,
		KIND_INVALID   = 4'd1,
		KIND_LBRACE    = 4'd2,
		KIND_RBRACE    = 4'd3,
		KIND_LBRACKET  = 4'd4,
		KIND_RBRACKET  = 4'd5,
		KIND_COLON     = 4'd6,
		KIND_COMMA     = 4'd7,
		KIND_STR_START = 4'd8,
		KIND_STR_CHAR  = 4'd9,
		KIND_STR_END   = 4'd10,
		KIND_INT       = 4'd11,
		KIND_REAL      = 4'd12,
		KIND_TRUE      = 4'd13,
		KIND_FALSE     = 4'd14,
		KIND_NULL      = 4'd15
	} kind_t;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_UPPER_E   = 8'h45;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_B   = 8'h62;
	localparam logic [7:0] CH_LOWER_E   = 8'h65;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CASE_BIT     = 8'h20;

	localparam logic [39:0] WORD_TRUE  = 40'h0074727565;
	localparam logic [39:0] WORD_FALSE = 40'h66616C7365;
	localparam logic [39:0] WORD_NULL  = 40'h006E756C6C;
	localparam logic [2:0]  LEN_FOUR   = 3'd4;
	localparam logic [2:0]  LEN_FIVE   = 3'd5;
	localparam logic [2:0]  LEN_SAT    = 3'd6;

	typedef struct packed {
		mode_t        mode;
		logic         negative_sign;
		logic [63:0]  magnitude;
		logic         overflowed;
		logic [39:0]  word_letters;
		logic [2:0]   word_length;
		logic         dropping;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		mode:          MODE_IDLE,
		negative_sign: 1'b0,
		magnitude:     64'd0,
		overflowed:    1'b0,
		word_letters:  40'd0,
		word_length:   3'd0,
		dropping:      1'b0
	};

	typedef struct packed {
		kind_t        kind;
		logic [7:0]   string_char;
		logic [63:0]  integer_value;
		logic         last_of_run;
	} result_t;

	typedef struct packed {
		result_t first;
		result_t second;
		logic    two;
	} result_pair_t;

	function automatic result_t make_result(input kind_t kind, input logic [7:0] ch,
			input logic [63:0] value);
		result_t r;
		r.kind          = kind;
		r.string_char   = ch;
		r.integer_value = value;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/jts_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON text channel
// One text byte, or an end mark, per word.
// ----------------------------------------------------------------------------
interface jts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source(output valid, output text_byte, output end_of_text, input ready);
	modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

// File: rtl/jts_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token channel
// One token event per word.
// ----------------------------------------------------------------------------
interface jts_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         token_kind;
	logic [7:0]         string_char;
	logic signed [63:0] integer_value;
	logic               last_of_run;

	modport source(output valid, output token_kind, output string_char,
		output integer_value, output last_of_run, input ready);
	modport sink(input valid, input token_kind, input string_char,
		input integer_value, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/json_token_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner
// Byte-serial JSON lexer: marks, strings, numbers and literal words as events.
//
//   channel  dir  handshake       payload
//   text     in   valid / ready   text_byte, end_of_text
//   token    out  valid / ready   token_kind, string_char, integer_value,
//                                 last_of_run
//
// One text byte is accepted per cycle while ready is high; its events are written
// to the queue at the next edge, and the queue offers them from its head entry.
// A byte that ends a valid number or word and is itself a mark gives two words;
// the token port moves one word per cycle unless stalled; such runs set the pace.
// ready holds low while the QUEUE_DEPTH entries are taken or committed.
// Reset clears the scan state and the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module json_token_scanner #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	jts_in_if.sink    text,
	jts_out_if.source token
);
	import jts_pkg::*;

	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              end_s1;
	scan_state_t       state_q;
	scan_state_t       next_state;
	result_pair_t      results;
	logic              any_result;
	logic              push;
	logic [FILL_W-1:0] level;
	logic [FILL_W:0]   committed;
	logic              accept;

	assign committed  = {1'b0, level} + {{FILL_W{1'b0}}, valid_s1};
	assign text.ready = committed < (FILL_W + 1)'(QUEUE_DEPTH);
	assign accept     = text.valid && text.ready;
	assign push       = valid_s1 && any_result;

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text.text_byte;
			end_s1  <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= SCAN_RESET;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				state_q <= next_state;
			end
		end
	end

	jts_scan_core u_core (
		.state       (state_q),
		.text_byte   (byte_s1),
		.end_of_text (end_s1),
		.next_state  (next_state),
		.results     (results),
		.any_result  (any_result)
	);

	jts_result_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (results),
		.level     (level),
		.token     (token)
	);

`ifndef SYNTH
	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted byte lost before scan stage");

	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && state_q.dropping && !end_s1 && (byte_s1 != CH_NUL) |-> !push)
		else $error("event produced while dropping");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (end_s1 || (byte_s1 == CH_NUL))
		|=> (state_q.mode == MODE_IDLE) && !state_q.dropping)
		else $error("scan state not cleared after end of text");

	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (end_s1 || (byte_s1 == CH_NUL)) |-> push)
		else $error("end of text gave no event");
`endif

endmodule
`default_nettype wire

// File: rtl/jts_scan_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner step logic
// Next scan state and up to two token events for one text byte.
// ----------------------------------------------------------------------------
module jts_scan_core (
	input  jts_pkg::scan_state_t  state,
	input  logic [7:0]            text_byte,
	input  logic                  end_of_text,
	output jts_pkg::scan_state_t  next_state,
	output jts_pkg::result_pair_t results,
	output logic                  any_result
);
	import jts_pkg::*;

	logic        at_end;
	logic        is_digit;
	logic        is_alpha;
	logic        is_exp_mark;
	logic [7:0]  lower;
	logic [3:0]  digit;
	logic [67:0] acc;
	logic        acc_over;
	logic [63:0] mag_next;
	logic        ovf_next;
	logic [39:0] letters_next;
	logic [2:0]  length_next;

	result_t     cl_ev;
	logic        cl_hit;
	logic        cl_ok;
	result_t     id_ev;
	logic        id_hit;
	scan_state_t id_st;

	result_t     ev_a;
	result_t     ev_b;
	logic        hit_a;
	logic        hit_b;
	scan_state_t nx;

	assign at_end      = end_of_text || (text_byte == CH_NUL);
	assign lower       = text_byte | CASE_BIT;
	assign is_digit    = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign is_alpha    = (lower >= CH_LOWER_A) && (lower <= CH_LOWER_Z);
	assign is_exp_mark = (text_byte == CH_LOWER_E) || (text_byte == CH_UPPER_E);
	assign digit       = 4'(text_byte - CH_ZERO);

	// ten times the magnitude plus the new digit; overflow above 2^63
	assign acc      = {1'b0, state.magnitude, 3'b000} + {3'b000, state.magnitude, 1'b0}
		+ {64'd0, digit};
	assign acc_over = acc > {4'd0, 1'b1, 63'd0};
	assign ovf_next = state.overflowed || acc_over;
	assign mag_next = ovf_next ? state.magnitude : acc[63:0];

	always_comb begin
		if (state.word_length < LEN_FIVE) begin
			letters_next = {state.word_letters[31:0], lower};
			length_next  = state.word_length + 3'd1;
		end else begin
			letters_next = state.word_letters;
			length_next  = LEN_SAT;
		end
	end

	// close the pending token
	always_comb begin
		cl_ev  = make_result(KIND_INVALID, 8'd0, 64'd0);
		cl_hit = 1'b1;
		cl_ok  = 1'b1;
		case (state.mode)
			MODE_IDLE: begin
				cl_hit = 1'b0;
			end
			MODE_ZERO, MODE_INT: begin
				if (state.overflowed || (!state.negative_sign && state.magnitude[63])) begin
					cl_ok = 1'b0;
				end else begin
					cl_ev = make_result(KIND_INT, 8'd0,
						state.negative_sign ? (64'd0 - state.magnitude) : state.magnitude);
				end
			end
			MODE_FRAC, MODE_EXP_DIG: begin
				cl_ev = make_result(KIND_REAL, 8'd0, 64'd0);
			end
			MODE_WORD: begin
				if (state.word_length == LEN_FOUR && state.word_letters == WORD_TRUE) begin
					cl_ev = make_result(KIND_TRUE, 8'd0, 64'd0);
				end else if (state.word_length == LEN_FIVE && state.word_letters == WORD_FALSE) begin
					cl_ev = make_result(KIND_FALSE, 8'd0, 64'd0);
				end else if (state.word_length == LEN_FOUR && state.word_letters == WORD_NULL) begin
					cl_ev = make_result(KIND_NULL, 8'd0, 64'd0);
				end else begin
					cl_ok = 1'b0;
				end
			end
			default: begin
				cl_ok = 1'b0;
			end
		endcase
	end

	// scan the byte from a cleared token
	always_comb begin
		id_ev  = make_result(KIND_INVALID, 8'd0, 64'd0);
		id_hit = 1'b1;
		id_st  = SCAN_RESET;
		case (text_byte)
			CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
				id_hit = 1'b0;
			end
			CH_LBRACE:   id_ev = make_result(KIND_LBRACE, 8'd0, 64'd0);
			CH_RBRACE:   id_ev = make_result(KIND_RBRACE, 8'd0, 64'd0);
			CH_LBRACKET: id_ev = make_result(KIND_LBRACKET, 8'd0, 64'd0);
			CH_RBRACKET: id_ev = make_result(KIND_RBRACKET, 8'd0, 64'd0);
			CH_COLON:    id_ev = make_result(KIND_COLON, 8'd0, 64'd0);
			CH_COMMA:    id_ev = make_result(KIND_COMMA, 8'd0, 64'd0);
			CH_QUOTE: begin
				id_ev      = make_result(KIND_STR_START, 8'd0, 64'd0);
				id_st.mode = MODE_STR;
			end
			CH_MINUS: begin
				id_hit              = 1'b0;
				id_st.negative_sign = 1'b1;
				id_st.mode          = MODE_SIGN;
			end
			CH_ZERO: begin
				id_hit     = 1'b0;
				id_st.mode = MODE_ZERO;
			end
			default: begin
				if (is_digit) begin
					id_hit          = 1'b0;
					id_st.magnitude = {60'd0, digit};
					id_st.mode      = MODE_INT;
				end else if (is_alpha) begin
					id_hit             = 1'b0;
					id_st.word_letters = {32'd0, lower};
					id_st.word_length  = 3'd1;
					id_st.mode         = MODE_WORD;
				end else begin
					id_st.dropping = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		logic rescan;
		logic fault;
		rescan = 1'b0;
		fault  = 1'b0;
		ev_a   = make_result(KIND_END, 8'd0, 64'd0);
		ev_b   = make_result(KIND_END, 8'd0, 64'd0);
		hit_a  = 1'b0;
		hit_b  = 1'b0;
		nx     = state;
		if (at_end) begin
			ev_a  = cl_ev;
			hit_a = !state.dropping && cl_hit;
			hit_b = 1'b1;
			nx    = SCAN_RESET;
		end else if (!state.dropping) begin
			case (state.mode)
				MODE_IDLE: begin
					ev_b  = id_ev;
					hit_b = id_hit;
					nx    = id_st;
				end
				MODE_STR: begin
					if (text_byte == CH_QUOTE) begin
						ev_b  = make_result(KIND_STR_END, 8'd0, 64'd0);
						hit_b = 1'b1;
						nx    = SCAN_RESET;
					end else if (text_byte == CH_BACKSLASH) begin
						nx.mode = MODE_ESC;
					end else begin
						ev_b  = make_result(KIND_STR_CHAR, text_byte, 64'd0);
						hit_b = 1'b1;
					end
				end
				MODE_ESC: begin
					hit_b   = 1'b1;
					nx.mode = MODE_STR;
					case (text_byte)
						CH_QUOTE, CH_BACKSLASH, CH_SLASH:
							ev_b = make_result(KIND_STR_CHAR, text_byte, 64'd0);
						CH_LOWER_B: ev_b = make_result(KIND_STR_CHAR, CH_BS, 64'd0);
						CH_LOWER_F: ev_b = make_result(KIND_STR_CHAR, CH_FF, 64'd0);
						CH_LOWER_N: ev_b = make_result(KIND_STR_CHAR, CH_LF, 64'd0);
						CH_LOWER_R: ev_b = make_result(KIND_STR_CHAR, CH_CR, 64'd0);
						CH_LOWER_T: ev_b = make_result(KIND_STR_CHAR, CH_TAB, 64'd0);
						default:    fault = 1'b1;
					endcase
				end
				MODE_SIGN: begin
					if (text_byte == CH_ZERO) begin
						nx.mode = MODE_ZERO;
					end else if (is_digit) begin
						nx.magnitude  = mag_next;
						nx.overflowed = ovf_next;
						nx.mode       = MODE_INT;
					end else begin
						rescan = 1'b1;
					end
				end
				MODE_ZERO, MODE_INT: begin
					if (is_digit) begin
						if (state.mode == MODE_ZERO) begin
							fault = 1'b1;
						end else begin
							nx.magnitude  = mag_next;
							nx.overflowed = ovf_next;
						end
					end else if (text_byte == CH_DOT) begin
						nx.mode = MODE_DOT;
					end else if (is_exp_mark) begin
						nx.mode = MODE_EXP;
					end else begin
						rescan = 1'b1;
					end
				end
				MODE_DOT: begin
					if (is_digit) begin
						nx.mode = MODE_FRAC;
					end else begin
						rescan = 1'b1;
					end
				end
				MODE_FRAC: begin
					if (is_exp_mark) begin
						nx.mode = MODE_EXP;
					end else if (!is_digit) begin
						rescan = 1'b1;
					end
				end
				MODE_EXP: begin
					if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
						nx.mode = MODE_EXP_SIGN;
					end else if (is_digit) begin
						nx.mode = MODE_EXP_DIG;
					end else begin
						rescan = 1'b1;
					end
				end
				MODE_EXP_SIGN, MODE_EXP_DIG: begin
					if (is_digit) begin
						nx.mode = MODE_EXP_DIG;
					end else begin
						rescan = 1'b1;
					end
				end
				MODE_WORD: begin
					if (is_alpha) begin
						nx.word_letters = letters_next;
						nx.word_length  = length_next;
					end else begin
						rescan = 1'b1;
					end
				end
				default: begin
					rescan = 1'b1;
				end
			endcase
			if (fault) begin
				ev_b        = make_result(KIND_INVALID, 8'd0, 64'd0);
				hit_b       = 1'b1;
				nx          = SCAN_RESET;
				nx.dropping = 1'b1;
			end
			if (rescan) begin
				ev_a  = cl_ev;
				hit_a = cl_hit;
				if (cl_ok) begin
					ev_b  = id_ev;
					hit_b = id_hit;
					nx    = id_st;
				end else begin
					nx          = SCAN_RESET;
					nx.dropping = 1'b1;
				end
			end
		end
	end

	always_comb begin
		results.first              = hit_a ? ev_a : ev_b;
		results.first.last_of_run  = !(hit_a && hit_b);
		results.second             = ev_b;
		results.second.last_of_run = 1'b1;
		results.two                = hit_a && hit_b;
	end

	assign any_result = hit_a || hit_b;
	assign next_state = nx;

endmodule
`default_nettype wire

// File: rtl/jts_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON token scanner result queue
// Holds the token events of each byte and hands them out one word at a time.
// ----------------------------------------------------------------------------
module jts_result_queue #(
	parameter int DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  jts_pkg::result_pair_t         push_data,
	output logic [$clog2(DEPTH+1)-1:0]    level,
	jts_out_if.source                     token
);
	import jts_pkg::*;

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	result_pair_t       mem_q [DEPTH];
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [FILL_W-1:0]  fill_q;
	logic               sub_q;
	result_pair_t       cur;
	result_t            word;
	logic               pop;
	logic               entry_done;

	assign cur        = mem_q[head_q];
	assign word       = sub_q ? cur.second : cur.first;
	assign pop        = token.valid && token.ready;
	assign entry_done = pop && (sub_q || !cur.two);

	assign token.valid         = fill_q != '0;
	assign token.token_kind    = word.kind;
	assign token.string_char   = word.string_char;
	assign token.integer_value = $signed(word.integer_value);
	assign token.last_of_run   = word.last_of_run;
	assign level               = fill_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			sub_q  <= 1'b0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (entry_done) begin
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
				sub_q  <= 1'b0;
			end else if (pop) begin
				sub_q <= 1'b1;
			end
			fill_q <= fill_q + FILL_W'(push) - FILL_W'(entry_done);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fill_q < FILL_W'(DEPTH)) || entry_done)
		else $error("result queue overflow");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DEPTH))
		else $error("result queue fill out of range");

	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> token.valid && cur.two)
		else $error("second word taken from a single-word entry");
`endif

endmodule
`default_nettype wire

// File: test/tb_json_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token scanner testbench
// Sends directed and random JSON text in bursts with gaps, works out every
// token event with a scanner model of its own and checks each token word in
// order while the token side stalls on changing patterns.
// ----------------------------------------------------------------------------
module tb_json_token_scanner;
	import jts_pkg::*;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          RANDOM_BYTES = 900;
	localparam int          PRINT_LIMIT  = 100;
	localparam logic [63:0] MAG_LIMIT    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] INT_MAX_MAG  = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic       feed_valid = 1'b0;
	logic [7:0] feed_byte  = 8'h00;
	logic       feed_end   = 1'b0;
	logic       take_ready = 1'b0;

	jts_in_if  text_ch();
	jts_out_if token_ch();

	assign text_ch.valid       = feed_valid;
	assign text_ch.text_byte   = feed_byte;
	assign text_ch.end_of_text = feed_end;
	assign token_ch.ready      = take_ready;

	json_token_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.token  (token_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_word_t text_words[$];
	result_t    expected_tokens[$];
	result_t    step_tokens[$];
	result_t    want;
	text_word_t next_word;

	int          stim_bytes  = 0;
	int          error_count = 0;
	int          token_words = 0;
	int          cycle_count = 0;
	int          burst_left  = 0;
	int          gap_left    = 0;
	int          stall_age   = 0;
	logic [15:0] stall_pattern = 16'hFFFF;

	// scanner state as seen by the prediction
	mode_t       pred_mode      = MODE_IDLE;
	logic        pred_negative  = 1'b0;
	logic [63:0] pred_magnitude = 64'd0;
	logic        pred_overflow  = 1'b0;
	logic [39:0] pred_letters   = 40'd0;
	logic [2:0]  pred_length    = 3'd0;
	logic        pred_dropping  = 1'b0;

	function automatic void note_token(kind_t kind, logic [7:0] ch, logic [63:0] value);
		result_t r;
		r.kind          = kind;
		r.string_char   = ch;
		r.integer_value = value;
		r.last_of_run   = 1'b0;
		if (step_tokens.size() < 2)
			step_tokens.push_back(r);
	endfunction

	function automatic void clear_token();
		pred_mode      = MODE_IDLE;
		pred_negative  = 1'b0;
		pred_magnitude = 64'd0;
		pred_overflow  = 1'b0;
		pred_letters   = 40'd0;
		pred_length    = 3'd0;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		logic [7:0] low;
		low = c | CASE_BIT;
		return low >= CH_LOWER_A && low <= CH_LOWER_Z;
	endfunction

	function automatic void add_digit(logic [7:0] c);
		logic [63:0] d;
		d = {56'd0, c - CH_ZERO};
		if (!pred_overflow) begin
			if (pred_magnitude > (MAG_LIMIT - d) / 64'd10)
				pred_overflow = 1'b1;
			else
				pred_magnitude = pred_magnitude * 64'd10 + d;
		end
	endfunction

	function automatic void add_letter(logic [7:0] c);
		if (pred_length < LEN_FIVE) begin
			pred_letters = {pred_letters[31:0], c | CASE_BIT};
			pred_length  = pred_length + 3'd1;
		end else begin
			pred_length = LEN_SAT;
		end
	endfunction

	function automatic void reject_token();
		note_token(KIND_INVALID, 8'h00, 64'd0);
		clear_token();
		pred_dropping = 1'b1;
	endfunction

	function automatic bit finish_token();
		bit ok;
		ok = 1'b1;
		case (pred_mode)
		MODE_IDLE: ;
		MODE_ZERO, MODE_INT: begin
			if (pred_overflow || (!pred_negative && pred_magnitude > INT_MAX_MAG)) begin
				note_token(KIND_INVALID, 8'h00, 64'd0);
				ok = 1'b0;
			end else begin
				note_token(KIND_INT, 8'h00,
					pred_negative ? 64'd0 - pred_magnitude : pred_magnitude);
			end
		end
		MODE_FRAC, MODE_EXP_DIG: note_token(KIND_REAL, 8'h00, 64'd0);
		MODE_WORD: begin
			if (pred_length == LEN_FOUR && pred_letters == WORD_TRUE) begin
				note_token(KIND_TRUE, 8'h00, 64'd0);
			end else if (pred_length == LEN_FIVE && pred_letters == WORD_FALSE) begin
				note_token(KIND_FALSE, 8'h00, 64'd0);
			end else if (pred_length == LEN_FOUR && pred_letters == WORD_NULL) begin
				note_token(KIND_NULL, 8'h00, 64'd0);
			end else begin
				note_token(KIND_INVALID, 8'h00, 64'd0);
				ok = 1'b0;
			end
		end
		default: begin
			note_token(KIND_INVALID, 8'h00, 64'd0);
			ok = 1'b0;
		end
		endcase
		clear_token();
		return ok;
	endfunction

	function automatic void scan_between_tokens(logic [7:0] c);
		case (c)
		CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
		CH_LBRACE:   note_token(KIND_LBRACE, 8'h00, 64'd0);
		CH_RBRACE:   note_token(KIND_RBRACE, 8'h00, 64'd0);
		CH_LBRACKET: note_token(KIND_LBRACKET, 8'h00, 64'd0);
		CH_RBRACKET: note_token(KIND_RBRACKET, 8'h00, 64'd0);
		CH_COLON:    note_token(KIND_COLON, 8'h00, 64'd0);
		CH_COMMA:    note_token(KIND_COMMA, 8'h00, 64'd0);
		CH_QUOTE: begin
			note_token(KIND_STR_START, 8'h00, 64'd0);
			pred_mode = MODE_STR;
		end
		CH_MINUS: begin
			pred_negative = 1'b1;
			pred_mode     = MODE_SIGN;
		end
		CH_ZERO: pred_mode = MODE_ZERO;
		default: begin
			if (is_digit(c)) begin
				add_digit(c);
				pred_mode = MODE_INT;
			end else if (is_letter(c)) begin
				add_letter(c);
				pred_mode = MODE_WORD;
			end else begin
				reject_token();
			end
		end
		endcase
	endfunction

	function automatic void finish_or_rescan(logic [7:0] c);
		if (finish_token())
			scan_between_tokens(c);
		else
			pred_dropping = 1'b1;
	endfunction

	function automatic void predict_tokens(logic [7:0] c, logic eot);
		bit         exp_mark;
		bit         esc_ok;
		logic [7:0] esc;
		step_tokens.delete();
		exp_mark = (c == CH_LOWER_E || c == CH_UPPER_E);
		esc_ok   = 1'b1;
		esc      = c;
		if (eot || c == CH_NUL) begin
			if (!pred_dropping)
				void'(finish_token());
			note_token(KIND_END, 8'h00, 64'd0);
			clear_token();
			pred_dropping = 1'b0;
		end else if (!pred_dropping) begin
			case (pred_mode)
			MODE_IDLE: scan_between_tokens(c);
			MODE_STR: begin
				if (c == CH_QUOTE) begin
					note_token(KIND_STR_END, 8'h00, 64'd0);
					clear_token();
				end else if (c == CH_BACKSLASH) begin
					pred_mode = MODE_ESC;
				end else begin
					note_token(KIND_STR_CHAR, c, 64'd0);
				end
			end
			MODE_ESC: begin
				case (c)
				CH_QUOTE, CH_BACKSLASH, CH_SLASH: esc = c;
				CH_LOWER_B: esc = CH_BS;
				CH_LOWER_F: esc = CH_FF;
				CH_LOWER_N: esc = CH_LF;
				CH_LOWER_R: esc = CH_CR;
				CH_LOWER_T: esc = CH_TAB;
				default:    esc_ok = 1'b0;
				endcase
				if (esc_ok) begin
					note_token(KIND_STR_CHAR, esc, 64'd0);
					pred_mode = MODE_STR;
				end else begin
					reject_token();
				end
			end
			MODE_SIGN: begin
				if (c == CH_ZERO) begin
					pred_mode = MODE_ZERO;
				end else if (is_digit(c)) begin
					add_digit(c);
					pred_mode = MODE_INT;
				end else begin
					finish_or_rescan(c);
				end
			end
			MODE_ZERO, MODE_INT: begin
				if (is_digit(c)) begin
					if (pred_mode == MODE_ZERO)
						reject_token();
					else
						add_digit(c);
				end else if (c == CH_DOT) begin
					pred_mode = MODE_DOT;
				end else if (exp_mark) begin
					pred_mode = MODE_EXP;
				end else begin
					finish_or_rescan(c);
				end
			end
			MODE_DOT: begin
				if (is_digit(c))
					pred_mode = MODE_FRAC;
				else
					finish_or_rescan(c);
			end
			MODE_FRAC: begin
				if (exp_mark)
					pred_mode = MODE_EXP;
				else if (!is_digit(c))
					finish_or_rescan(c);
			end
			MODE_EXP: begin
				if (c == CH_PLUS || c == CH_MINUS)
					pred_mode = MODE_EXP_SIGN;
				else if (is_digit(c))
					pred_mode = MODE_EXP_DIG;
				else
					finish_or_rescan(c);
			end
			MODE_EXP_SIGN, MODE_EXP_DIG: begin
				if (is_digit(c))
					pred_mode = MODE_EXP_DIG;
				else
					finish_or_rescan(c);
			end
			MODE_WORD: begin
				if (is_letter(c))
					add_letter(c);
				else
					finish_or_rescan(c);
			end
			default: finish_or_rescan(c);
			endcase
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.push_back(step_tokens[i]);
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_value);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("MISMATCH token word %0d: %s got %0h expected %0h",
				token_words, what, got, exp_value);
	endtask

	task automatic push_byte(logic [7:0] b);
		text_words.push_back({b, 1'b0});
		stim_bytes++;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_end();
		if ($urandom_range(0, 3) == 0)
			text_words.push_back({CH_NUL, 1'b0});
		else
			text_words.push_back({8'($urandom), 1'b1});
	endtask

	task automatic push_digits(int count, bit lead_nonzero);
		for (int i = 0; i < count; i++) begin
			if (i == 0 && lead_nonzero)
				push_byte(CH_ZERO + 8'($urandom_range(1, 9)));
			else
				push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	task automatic push_random_token();
		int         pick;
		bit         has_dot;
		string      lit;
		logic [7:0] c;
		pick = $urandom_range(0, 27);
		if (pick < 9) begin
			case ($urandom_range(0, 5))
			0: push_byte(CH_LBRACE);
			1: push_byte(CH_RBRACE);
			2: push_byte(CH_LBRACKET);
			3: push_byte(CH_RBRACKET);
			4: push_byte(CH_COLON);
			default: push_byte(CH_COMMA);
			endcase
		end else if (pick < 15) begin
			push_byte(CH_QUOTE);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 4))
				0: begin
					push_byte(CH_BACKSLASH);
					case ($urandom_range(0, 7))
					0: push_byte(CH_QUOTE);
					1: push_byte(CH_BACKSLASH);
					2: push_byte(CH_SLASH);
					3: push_byte(CH_LOWER_B);
					4: push_byte(CH_LOWER_F);
					5: push_byte(CH_LOWER_N);
					6: push_byte(CH_LOWER_R);
					default: push_byte(CH_LOWER_T);
					endcase
				end
				1: begin
					c = 8'($urandom_range(1, 255));
					if (c == CH_QUOTE || c == CH_BACKSLASH)
						c = c ^ 8'h01;
					push_byte(c);
				end
				default: begin
					c = 8'($urandom_range(32, 126));
					if (c == CH_QUOTE || c == CH_BACKSLASH)
						c = c ^ 8'h01;
					push_byte(c);
				end
				endcase
			end
			push_byte(CH_QUOTE);
		end else if (pick < 20) begin
			if ($urandom_range(0, 1) == 1)
				push_byte(CH_MINUS);
			case ($urandom_range(0, 7))
			0: push_byte(CH_ZERO);
			1: begin
				// straddle the signed 64-bit limits
				push_text("922337203685477580");
				push_byte(CH_ZERO + 8'($urandom_range(5, 9)));
			end
			2: push_digits($urandom_range(18, 21), 1'b1);
			default: push_digits($urandom_range(1, 6), 1'b1);
			endcase
		end else if (pick < 23) begin
			if ($urandom_range(0, 1) == 1)
				push_byte(CH_MINUS);
			if ($urandom_range(0, 2) == 0)
				push_byte(CH_ZERO);
			else
				push_digits($urandom_range(1, 4), 1'b1);
			has_dot = ($urandom_range(0, 3) != 0);
			if (has_dot) begin
				push_byte(CH_DOT);
				push_digits($urandom_range(1, 4), 1'b0);
			end
			if (!has_dot || $urandom_range(0, 1) == 1) begin
				push_byte(($urandom_range(0, 1) == 1) ? CH_LOWER_E : CH_UPPER_E);
				case ($urandom_range(0, 2))
				0: push_byte(CH_PLUS);
				1: push_byte(CH_MINUS);
				default: ;
				endcase
				push_digits($urandom_range(1, 3), 1'b0);
			end
		end else if (pick < 27) begin
			lit = "";
			case ($urandom_range(0, 3))
			0: lit = "true";
			1: lit = "false";
			2: lit = "null";
			default: begin
				repeat ($urandom_range(1, 7))
					push_byte(8'($urandom_range(CH_LOWER_A, CH_LOWER_Z))
						^ (($urandom_range(0, 1) == 1) ? CASE_BIT : 8'h00));
			end
			endcase
			for (int i = 0; i < lit.len(); i++) begin
				c = lit[i];
				if ($urandom_range(0, 1) == 1)
					c = c ^ CASE_BIT;
				push_byte(c);
			end
		end else begin
			case ($urandom_range(0, 5))
			0: push_text("-");
			1: push_text("1.");
			2: push_text("2e+");
			3: push_text("01");
			4: push_text("\"\\x");
			default: push_byte(8'($urandom_range(1, 255)));
			endcase
		end
	endtask

	// text side: bursts of words with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (feed_valid && text_ch.ready)
				predict_tokens(feed_byte, feed_end);
			if (!feed_valid || text_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					feed_valid <= 1'b0;
				end else if (text_words.size() > 0) begin
					next_word = text_words.pop_front();
					feed_valid <= 1'b1;
					feed_byte  <= next_word.text_byte;
					feed_end   <= next_word.end_of_text;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					feed_valid <= 1'b0;
				end
			end
		end
	end

	// token side: check each word, stall on a rotating pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_ready <= 1'b0;
		end else begin
			if (token_ch.valid && take_ready) begin
				token_words++;
				if (expected_tokens.size() == 0) begin
					report_mismatch("unexpected word, token_kind",
						64'(token_ch.token_kind), 64'd0);
				end else begin
					want = expected_tokens.pop_front();
					if (token_ch.token_kind !== want.kind)
						report_mismatch("token_kind", 64'(token_ch.token_kind),
							64'(want.kind));
					if (token_ch.string_char !== want.string_char)
						report_mismatch("string_char", 64'(token_ch.string_char),
							64'(want.string_char));
					if (token_ch.integer_value !== want.integer_value)
						report_mismatch("integer_value", token_ch.integer_value,
							want.integer_value);
					if (token_ch.last_of_run !== want.last_of_run)
						report_mismatch("last_of_run", 64'(token_ch.last_of_run),
							64'(want.last_of_run));
				end
			end
			if (stall_age == 0) begin
				stall_age = $urandom_range(40, 160);
				case ($urandom_range(0, 3))
				0: stall_pattern = 16'hFFFF;
				1: stall_pattern = 16'($urandom) | 16'h0001;
				2: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
				default: stall_pattern = 16'($urandom | $urandom) | 16'h0001;
				endcase
			end else begin
				stall_age--;
			end
			take_ready <= stall_pattern[0];
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		push_text("{\"k\\\"\\\\\\/\\b\\f\\n\\r\\t\":[-0,7,-12]}");
		text_words.push_back({CH_LBRACE, 1'b1});
		push_text("9223372036854775807 -9223372036854775808 1.25e+3 0.5E-1 4e2 -0.0");
		text_words.push_back({CH_NUL, 1'b0});
		push_text("9223372036854775808");
		push_end();
		push_text("-9223372036854775809");
		push_end();
		push_text("[TRUE,False,nUlL]1}");
		push_end();
		push_text("nullnull {");
		push_end();
		push_text("truex");
		push_end();
		push_text("falsey");
		push_end();
		push_text("tr");
		push_end();
		push_text("01");
		push_end();
		push_text("\"ab");
		push_end();
		push_text("\"\\");
		push_end();
		push_text("\"\\q\"");
		push_end();
		push_text("-");
		push_end();
		push_text("1.");
		push_end();
		push_text("1e+");
		push_end();
		push_text("- 1");
		push_end();
		push_byte(CH_QUOTE);
		push_byte(8'hFF);
		push_byte(CH_QUOTE);
		push_byte(CH_CR);
		push_byte(CH_TAB);
		push_byte(CH_LF);
		push_byte(8'hFF);
		push_end();

		while (stim_bytes < RANDOM_BYTES) begin
			repeat ($urandom_range(1, 12)) begin
				push_random_token();
				case ($urandom_range(0, 7))
				0: ;
				1, 2: push_byte(CH_COMMA);
				3: push_byte(CH_COLON);
				4: push_byte(CH_SPACE);
				5: push_byte(CH_TAB);
				6: push_byte(CH_LF);
				default: push_byte(CH_CR);
				endcase
			end
			push_end();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (text_words.size() != 0 || feed_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_tokens.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/jts_pkg.sv
rtl/jts_in_if.sv
rtl/jts_out_if.sv
rtl/jts_scan_core.sv
rtl/jts_result_queue.sv
rtl/json_token_scanner.sv
test/tb_json_token_scanner.sv
